### src/jfsd_pkg.sv
// Package for the J1939 frame signal decoder: identifiers, frame kinds,
// signal codes, queue entry type and the per-kind signal count.
// Depends on nothing; used by every module of the block.
package jfsd_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

    localparam logic [28:0] ID_CCVS  = 29'h18FEF100;
    localparam logic [28:0] ID_EEC1  = 29'h0CF00400;
    localparam logic [28:0] ID_EEC2  = 29'h0CF00300;
    localparam logic [28:0] ID_VDHR  = 29'h18FEC100;
    localparam logic [28:0] ID_ET1   = 29'h18FEEE00;
    localparam logic [28:0] ID_AMB   = 29'h18FEF500;
    localparam logic [28:0] ID_VEP1  = 29'h18FEF700;
    localparam logic [28:0] ID_EGF1  = 29'h0CF00A00;
    localparam logic [28:0] ID_DM1   = 29'h18FECA00;
    localparam logic [28:0] ID_HOURS = 29'h18FEE700;
    localparam logic [28:0] ID_FUEL  = 29'h18FEE900;
    localparam logic [28:0] ID_RATE  = 29'h18FEF200;

    localparam logic [3:0] DLC_FULL = 4'd8;

    localparam logic [4:0] SIG_PARK_BRAKE   = 5'd0;
    localparam logic [4:0] SIG_BRAKE_SWITCH = 5'd1;
    localparam logic [4:0] SIG_SPEED        = 5'd2;
    localparam logic [4:0] SIG_RPM          = 5'd3;
    localparam logic [4:0] SIG_LOAD         = 5'd4;
    localparam logic [4:0] SIG_TOTAL_DIST   = 5'd5;
    localparam logic [4:0] SIG_TRIP_DIST    = 5'd6;
    localparam logic [4:0] SIG_COOLANT      = 5'd7;
    localparam logic [4:0] SIG_FUEL_TEMP    = 5'd8;
    localparam logic [4:0] SIG_AIR_TEMP     = 5'd9;
    localparam logic [4:0] SIG_ELEC_VOLT    = 5'd10;
    localparam logic [4:0] SIG_BATT_VOLT    = 5'd11;
    localparam logic [4:0] SIG_AIR_FLOW     = 5'd12;
    localparam logic [4:0] SIG_FAULTS       = 5'd13;
    localparam logic [4:0] SIG_HOURS        = 5'd14;
    localparam logic [4:0] SIG_TRIP_FUEL    = 5'd15;
    localparam logic [4:0] SIG_TOTAL_FUEL   = 5'd16;
    localparam logic [4:0] SIG_FUEL_RATE    = 5'd17;

    localparam logic [15:0] RAW16_MAX = 16'd64255;
    localparam logic [31:0] HOURS_MAX = 32'd4211081215;
    localparam logic [7:0]  LOAD_MAX  = 8'd125;
    localparam logic [7:0]  TEMP_OFFSET = 8'd40;
    localparam logic signed [32:0] TEMP_MAX = 33'sd210;

    typedef enum logic [3:0] {
        KIND_CCVS,
        KIND_EEC1,
        KIND_EEC2,
        KIND_VDHR,
        KIND_ET1,
        KIND_AMB,
        KIND_VEP1,
        KIND_EGF1,
        KIND_DM1,
        KIND_HOURS,
        KIND_FUEL,
        KIND_RATE
    } frame_kind_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [63:0] payload;
    } frame_entry_t;

    typedef struct packed {
        logic         valid;
        frame_entry_t entry;
    } queue_head_t;

    // Number of signals that one frame of the given kind yields, minus one.
    function automatic logic [1:0] last_index(input frame_kind_t kind);
        logic [1:0] n;
        unique case (kind)
            KIND_CCVS:                                 n = 2'd2;
            KIND_VDHR, KIND_ET1, KIND_VEP1, KIND_FUEL: n = 2'd1;
            default:                                   n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

### src/jfsd_front.sv
// Front end of the J1939 frame signal decoder: accepts a frame and
// classifies its identifier. Depends on jfsd_pkg.
module jfsd_front (
    input  logic                  accept,
    input  logic [28:0]           frame_id,
    input  logic [3:0]            data_length,
    input  logic [63:0]           payload,
    output logic                  push,
    output jfsd_pkg::frame_entry_t entry
);

    logic                  matched;
    jfsd_pkg::frame_kind_t kind;
    logic                  full;

    assign full = (data_length == jfsd_pkg::DLC_FULL);

    always_comb
    begin
        matched = 1'b1;
        kind    = jfsd_pkg::KIND_RATE;
        unique case (frame_id)
            jfsd_pkg::ID_CCVS:
            begin
                kind    = jfsd_pkg::KIND_CCVS;
                matched = full;
            end
            jfsd_pkg::ID_EEC1:
            begin
                kind    = jfsd_pkg::KIND_EEC1;
                matched = full;
            end
            jfsd_pkg::ID_EEC2:
            begin
                kind    = jfsd_pkg::KIND_EEC2;
                matched = full;
            end
            jfsd_pkg::ID_VDHR:  kind = jfsd_pkg::KIND_VDHR;
            jfsd_pkg::ID_ET1:   kind = jfsd_pkg::KIND_ET1;
            jfsd_pkg::ID_AMB:   kind = jfsd_pkg::KIND_AMB;
            jfsd_pkg::ID_VEP1:  kind = jfsd_pkg::KIND_VEP1;
            jfsd_pkg::ID_EGF1:  kind = jfsd_pkg::KIND_EGF1;
            jfsd_pkg::ID_DM1:   kind = jfsd_pkg::KIND_DM1;
            jfsd_pkg::ID_HOURS: kind = jfsd_pkg::KIND_HOURS;
            jfsd_pkg::ID_FUEL:  kind = jfsd_pkg::KIND_FUEL;
            jfsd_pkg::ID_RATE:  kind = jfsd_pkg::KIND_RATE;
            default:            matched = 1'b0;
        endcase
    end

    // Frames that yield nothing never enter the queue.
    assign push          = accept && matched;
    assign entry.kind    = kind;
    assign entry.payload = payload;

endmodule

### src/jfsd_queue.sv
// Short queue of classified frames between front and back end of the
// J1939 frame signal decoder. Depends on jfsd_pkg.
module jfsd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  jfsd_pkg::frame_entry_t push_entry,
    input  logic                   pop,
    output jfsd_pkg::queue_head_t  head,
    output logic                   full
);

    jfsd_pkg::frame_entry_t                  slot_reg [jfsd_pkg::QueueDepth];
    logic [jfsd_pkg::QueuePtrW-1:0]          wr_ptr_reg;
    logic [jfsd_pkg::QueuePtrW-1:0]          wr_ptr_next;
    logic [jfsd_pkg::QueuePtrW-1:0]          rd_ptr_reg;
    logic [jfsd_pkg::QueuePtrW-1:0]          rd_ptr_next;
    logic [jfsd_pkg::QueuePtrW:0]            count_reg;
    logic [jfsd_pkg::QueuePtrW:0]            count_next;
    logic                                    do_pop;

    assign do_pop = pop && (count_reg != '0);
    assign full   = (count_reg == (jfsd_pkg::QueuePtrW+1)'(jfsd_pkg::QueueDepth));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (jfsd_pkg::QueuePtrW+1)'(push)
                    - (jfsd_pkg::QueuePtrW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

endmodule

### src/jfsd_back.sv
// Back end of the J1939 frame signal decoder: decodes the signals of the
// frame at the head of the queue, one per cycle. Depends on jfsd_pkg.
module jfsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  jfsd_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  result_valid,
    output logic [4:0]            signal_code,
    output logic signed [32:0]    signal_value,
    output logic                  last_of_frame
);

    logic [1:0]            index_reg;
    logic [1:0]            index_next;
    logic                  valid_reg;
    logic [4:0]            code_reg;
    logic [4:0]            code_next;
    logic signed [32:0]    value_reg;
    logic signed [32:0]    value_next;
    logic                  last_reg;
    logic                  last_next;
    logic [63:0]           p;

    assign p = head.entry.payload;

    function automatic logic signed [32:0] clamp16(input logic [15:0] w);
        logic [15:0] c;
        c = (w > jfsd_pkg::RAW16_MAX) ? jfsd_pkg::RAW16_MAX : w;
        return $signed({17'd0, c});
    endfunction

    function automatic logic signed [32:0] word32(input logic [31:0] w);
        return $signed({1'b0, w});
    endfunction

    // The byte minus the offset can never fall below -40, so only the top
    // of the range needs clamping.
    function automatic logic signed [32:0] temp_of(input logic [7:0] b);
        logic signed [32:0] t;
        t = $signed({25'd0, b}) - $signed({25'd0, jfsd_pkg::TEMP_OFFSET});
        return (t > jfsd_pkg::TEMP_MAX) ? jfsd_pkg::TEMP_MAX : t;
    endfunction

    always_comb
    begin
        code_next  = jfsd_pkg::SIG_FUEL_RATE;
        value_next = '0;
        unique case (head.entry.kind)
            jfsd_pkg::KIND_CCVS:
            begin
                unique case (index_reg)
                    2'd0:
                    begin
                        code_next  = jfsd_pkg::SIG_PARK_BRAKE;
                        value_next = $signed({31'd0, p[3:2]});
                    end
                    2'd1:
                    begin
                        code_next  = jfsd_pkg::SIG_BRAKE_SWITCH;
                        value_next = $signed({31'd0, p[29:28]});
                    end
                    default:
                    begin
                        code_next  = jfsd_pkg::SIG_SPEED;
                        value_next = clamp16(p[23:8]);
                    end
                endcase
            end
            jfsd_pkg::KIND_EEC1:
            begin
                code_next  = jfsd_pkg::SIG_RPM;
                value_next = clamp16(p[39:24]);
            end
            jfsd_pkg::KIND_EEC2:
            begin
                code_next  = jfsd_pkg::SIG_LOAD;
                value_next = $signed({25'd0, (p[23:16] > jfsd_pkg::LOAD_MAX)
                                             ? jfsd_pkg::LOAD_MAX : p[23:16]});
            end
            jfsd_pkg::KIND_VDHR:
            begin
                code_next  = index_reg[0] ? jfsd_pkg::SIG_TRIP_DIST
                                          : jfsd_pkg::SIG_TOTAL_DIST;
                value_next = word32(index_reg[0] ? p[63:32] : p[31:0]);
            end
            jfsd_pkg::KIND_ET1:
            begin
                code_next  = index_reg[0] ? jfsd_pkg::SIG_FUEL_TEMP
                                          : jfsd_pkg::SIG_COOLANT;
                value_next = temp_of(index_reg[0] ? p[15:8] : p[7:0]);
            end
            jfsd_pkg::KIND_AMB:
            begin
                code_next  = jfsd_pkg::SIG_AIR_TEMP;
                value_next = temp_of(p[47:40]);
            end
            jfsd_pkg::KIND_VEP1:
            begin
                code_next  = index_reg[0] ? jfsd_pkg::SIG_BATT_VOLT
                                          : jfsd_pkg::SIG_ELEC_VOLT;
                value_next = clamp16(index_reg[0] ? p[63:48] : p[47:32]);
            end
            jfsd_pkg::KIND_EGF1:
            begin
                code_next  = jfsd_pkg::SIG_AIR_FLOW;
                value_next = clamp16(p[31:16]);
            end
            jfsd_pkg::KIND_DM1:
            begin
                code_next  = jfsd_pkg::SIG_FAULTS;
                value_next = $signed({26'd0, p[46:40]});
            end
            jfsd_pkg::KIND_HOURS:
            begin
                code_next  = jfsd_pkg::SIG_HOURS;
                value_next = word32((p[31:0] > jfsd_pkg::HOURS_MAX)
                                    ? jfsd_pkg::HOURS_MAX : p[31:0]);
            end
            jfsd_pkg::KIND_FUEL:
            begin
                code_next  = index_reg[0] ? jfsd_pkg::SIG_TOTAL_FUEL
                                          : jfsd_pkg::SIG_TRIP_FUEL;
                value_next = word32(index_reg[0] ? p[63:32] : p[31:0]);
            end
            default:
            begin
                code_next  = jfsd_pkg::SIG_FUEL_RATE;
                value_next = clamp16(p[15:0]);
            end
        endcase
    end

    always_comb
    begin
        last_next  = (index_reg == jfsd_pkg::last_index(head.entry.kind));
        pop        = head.valid && last_next;
        index_next = !head.valid ? index_reg
                   : (last_next ? 2'd0 : index_reg + 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            index_reg <= index_next;
            valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg  <= code_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    assign result_valid  = valid_reg;
    assign signal_code   = code_reg;
    assign signal_value  = value_reg;
    assign last_of_frame = last_reg;

endmodule

### src/j1939_frame_signal_decoder_unit.sv
// Top level of the J1939 frame signal decoder.
// Depends on jfsd_pkg, jfsd_front, jfsd_queue and jfsd_back.
//
// A received CAN frame is presented on frame_id, data_length and payload
// with start held high; the transaction is accepted at the rising edge at
// which start is high and busy is low. The front end compares the
// identifier against the twelve supported J1939 identifiers and drops
// frames that yield nothing (unmatched identifiers, and CCVS, EEC1 or EEC2
// frames whose DLC is not 8). Matching frames enter a four-entry queue.
// The back end decodes one signal per clock cycle from the frame at the
// head of the queue; a frame holds the head until its last signal is decoded. Each
// result is shown on signal_code, signal_value and last_of_frame for exactly
// one cycle with result_valid high; the receiver cannot hold results off
// and must take it then. last_of_frame marks the final signal of a frame.
// With the queue empty, an accepted frame is first registered into the
// queue and its first result then into the back end's output registers.
// Frames may be accepted back to back; over a long burst the back end sets
// the pace, and busy is high only while the queue is full.
// Reset empties the queue and clears the result strobe.
module j1939_frame_signal_decoder_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [28:0]         frame_id,
    input  logic [3:0]          data_length,
    input  logic [63:0]         payload,
    output logic                result_valid,
    output logic [4:0]          signal_code,
    output logic signed [32:0]  signal_value,
    output logic                last_of_frame
);

    logic                   accept;
    logic                   push;
    logic                   pop;
    logic                   queue_full;
    jfsd_pkg::frame_entry_t push_entry;
    jfsd_pkg::queue_head_t  head;

    // A transaction is taken whenever the queue has room for it; since the
    // back end pops an entry with its last signal, the queue only fills
    // under a sustained burst of multi-signal frames.
    assign busy   = queue_full;
    assign accept = start && !queue_full;

    jfsd_front u_front (
        .accept      (accept),
        .frame_id    (frame_id),
        .data_length (data_length),
        .payload     (payload),
        .push        (push),
        .entry       (push_entry)
    );

    jfsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (queue_full)
    );

    // The back end pops the head entry at the edge that registers the entry's
    // last signal, so the next frame follows without a gap.
    jfsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .result_valid  (result_valid),
        .signal_code   (signal_code),
        .signal_value  (signal_value),
        .last_of_frame (last_of_frame)
    );

endmodule

### sim/j1939_frame_signal_decoder_unit_test.sv
// Self-checking testbench for the J1939 frame signal decoder top level.
// Depends on jfsd_pkg and j1939_frame_signal_decoder_unit; it reads no files
// and predicts every decoded signal from its own model of the decoding rules.
`timescale 1ns / 1ps

module j1939_frame_signal_decoder_unit_test;

    // The slowest legal run is about two hundred frames, each with at most
    // the longest drawn idle gap and its time in the back end. This limit is
    // many times that figure.
    localparam int unsigned RUN_LIMIT     = 200000;
    localparam int unsigned RANDOM_FRAMES = 155;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // One decoded signal as the block should present it.
    typedef struct {
        logic [4:0]         code;
        logic signed [32:0] value;
        logic               last;
    } decoded_signal_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [28:0]        frame_id = '0;
    logic [3:0]         data_length = '0;
    logic [63:0]        payload = '0;
    logic               result_valid;
    logic [4:0]         signal_code;
    logic signed [32:0] signal_value;
    logic               last_of_frame;

    // Signals still owed by the block, oldest first.
    decoded_signal_t pending_signals[$];

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    // Largest idle gap the sender may draw before its next transaction.
    int unsigned sender_gap_max = 0;
    // Value of busy during the cycle that the coming rising edge closes.
    logic        busy_before_edge = 1'b0;

    j1939_frame_signal_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .frame_id      (frame_id),
        .data_length   (data_length),
        .payload       (payload),
        .result_valid  (result_valid),
        .signal_code   (signal_code),
        .signal_value  (signal_value),
        .last_of_frame (last_of_frame)
    );

    always #5 clk = ~clk;

    // busy only moves at rising edges, so its value at the falling edge is
    // the value that the next rising edge will see. Sampling it here keeps
    // the acceptance decision free of any race with the block's own logic.
    always @(negedge clk)
    begin
        busy_before_edge = busy;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction of the decoded signals
    // ------------------------------------------------------------------

    // 16-bit quantities saturate at the top of the valid J1939 range; the
    // values above it are reserved for error and not-available codes.
    function automatic logic [32:0] clamp_raw16(input logic [15:0] raw);
        return (raw > jfsd_pkg::RAW16_MAX) ? {17'd0, jfsd_pkg::RAW16_MAX} : {17'd0, raw};
    endfunction

    // Temperatures carry a 40 degree offset. A raw zero already gives the
    // lower limit of -40, so only the upper limit needs an explicit clamp.
    function automatic logic [32:0] temperature_of(input logic [7:0] raw);
        int                 degrees;
        logic signed [32:0] result;
        degrees = int'(raw) - int'(jfsd_pkg::TEMP_OFFSET);
        if (degrees > 210)
        begin
            degrees = 210;
        end
        result = 33'(degrees);
        return result;
    endfunction

    function automatic void push_signal(input logic [4:0] code, input logic [32:0] value);
        decoded_signal_t item;
        item.code  = code;
        item.value = value;
        item.last  = 1'b0;
        pending_signals.push_back(item);
    endfunction

    // Appends the signals that one accepted frame yields and marks the last
    // of them. Frames that yield nothing leave the store untouched.
    function automatic void predict_frame_signals(input logic [28:0] id,
                                                  input logic [3:0]  dlc,
                                                  input logic [63:0] data);
        logic        full_frame;
        int unsigned first_new;
        full_frame = (dlc == jfsd_pkg::DLC_FULL);
        first_new  = pending_signals.size();
        case (id)
            jfsd_pkg::ID_CCVS:
            begin
                // The powertrain frames are only trusted with all eight bytes.
                if (full_frame)
                begin
                    push_signal(jfsd_pkg::SIG_PARK_BRAKE, {31'd0, data[3:2]});
                    push_signal(jfsd_pkg::SIG_BRAKE_SWITCH, {31'd0, data[29:28]});
                    push_signal(jfsd_pkg::SIG_SPEED, clamp_raw16(data[23:8]));
                end
            end
            jfsd_pkg::ID_EEC1:
            begin
                if (full_frame)
                begin
                    push_signal(jfsd_pkg::SIG_RPM, clamp_raw16(data[39:24]));
                end
            end
            jfsd_pkg::ID_EEC2:
            begin
                if (full_frame)
                begin
                    push_signal(jfsd_pkg::SIG_LOAD, (data[23:16] > jfsd_pkg::LOAD_MAX) ?
                                {25'd0, jfsd_pkg::LOAD_MAX} : {25'd0, data[23:16]});
                end
            end
            jfsd_pkg::ID_VDHR:
            begin
                push_signal(jfsd_pkg::SIG_TOTAL_DIST, {1'b0, data[31:0]});
                push_signal(jfsd_pkg::SIG_TRIP_DIST, {1'b0, data[63:32]});
            end
            jfsd_pkg::ID_ET1:
            begin
                push_signal(jfsd_pkg::SIG_COOLANT, temperature_of(data[7:0]));
                push_signal(jfsd_pkg::SIG_FUEL_TEMP, temperature_of(data[15:8]));
            end
            jfsd_pkg::ID_AMB:
            begin
                push_signal(jfsd_pkg::SIG_AIR_TEMP, temperature_of(data[47:40]));
            end
            jfsd_pkg::ID_VEP1:
            begin
                push_signal(jfsd_pkg::SIG_ELEC_VOLT, clamp_raw16(data[47:32]));
                push_signal(jfsd_pkg::SIG_BATT_VOLT, clamp_raw16(data[63:48]));
            end
            jfsd_pkg::ID_EGF1:
            begin
                push_signal(jfsd_pkg::SIG_AIR_FLOW, clamp_raw16(data[31:16]));
            end
            jfsd_pkg::ID_DM1:
            begin
                push_signal(jfsd_pkg::SIG_FAULTS, {26'd0, data[46:40]});
            end
            jfsd_pkg::ID_HOURS:
            begin
                push_signal(jfsd_pkg::SIG_HOURS, (data[31:0] > jfsd_pkg::HOURS_MAX) ?
                            {1'b0, jfsd_pkg::HOURS_MAX} : {1'b0, data[31:0]});
            end
            jfsd_pkg::ID_FUEL:
            begin
                push_signal(jfsd_pkg::SIG_TRIP_FUEL, {1'b0, data[31:0]});
                push_signal(jfsd_pkg::SIG_TOTAL_FUEL, {1'b0, data[63:32]});
            end
            jfsd_pkg::ID_RATE:
            begin
                push_signal(jfsd_pkg::SIG_FUEL_RATE, clamp_raw16(data[15:0]));
            end
            default:
            begin
            end
        endcase
        if (pending_signals.size() > first_new)
        begin
            pending_signals[pending_signals.size() - 1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    // The receiver cannot stall the block, so every strobe is one result.
    // Outputs are sampled at the falling edge, well clear of the rising
    // edge at which they change.
    always @(negedge clk)
    begin
        decoded_signal_t wanted;
        if (rst_n && result_valid)
        begin
            if (pending_signals.size() == 0)
            begin
                $error("unexpected result: signal_code %0d, signal_value %0d",
                       signal_code, signal_value);
                error_count++;
            end
            else
            begin
                wanted = pending_signals.pop_front();
                if (signal_code !== wanted.code)
                begin
                    $error("signal_code: expected %0d, got %0d", wanted.code, signal_code);
                    error_count++;
                end
                if (signal_value !== wanted.value)
                begin
                    $error("signal_value: expected %0d, got %0d",
                           wanted.value, signal_value);
                    error_count++;
                end
                if (last_of_frame !== wanted.last)
                begin
                    $error("last_of_frame: expected %0d, got %0d",
                           wanted.last, last_of_frame);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Sends one frame. It is entered just after a rising edge, either the
    // start of the run or the edge that accepted the previous transaction,
    // and returns just after the edge that accepts this one. start is only
    // lowered when a gap is drawn, so a back-to-back frame never sees start
    // dropped and raised in the same time step.
    task automatic transmit_frame(input logic [28:0] id,
                                  input logic [3:0]  dlc,
                                  input logic [63:0] data);
        int unsigned gap;
        logic        accepted;
        gap = $urandom_range(0, sender_gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        frame_id    <= id;
        data_length <= dlc;
        payload     <= data;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(posedge clk);
            accepted = !busy_before_edge;
        end
        predict_frame_signals(id, dlc, data);
    endtask

    function automatic logic [28:0] known_frame_id(input int unsigned idx);
        case (idx)
            0:       return jfsd_pkg::ID_CCVS;
            1:       return jfsd_pkg::ID_EEC1;
            2:       return jfsd_pkg::ID_EEC2;
            3:       return jfsd_pkg::ID_VDHR;
            4:       return jfsd_pkg::ID_ET1;
            5:       return jfsd_pkg::ID_AMB;
            6:       return jfsd_pkg::ID_VEP1;
            7:       return jfsd_pkg::ID_EGF1;
            8:       return jfsd_pkg::ID_DM1;
            9:       return jfsd_pkg::ID_HOURS;
            10:      return jfsd_pkg::ID_FUEL;
            default: return jfsd_pkg::ID_RATE;
        endcase
    endfunction

    // Payload bytes lean towards the values around the clamp limits and the
    // temperature offset, so that both sides of every limit are reached.
    function automatic logic [63:0] random_payload();
        logic [63:0] data;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 9))
                0:       data[8*i +: 8] = 8'h00;
                1:       data[8*i +: 8] = 8'hFF;
                2:       data[8*i +: 8] = 8'hFA;
                3:       data[8*i +: 8] = 8'hFB;
                4:       data[8*i +: 8] = 8'($urandom_range(124, 126));
                5:       data[8*i +: 8] = 8'($urandom_range(39, 41));
                default: data[8*i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return data;
    endfunction

    task automatic test_directed_frames();
        sender_gap_max = 2;
        // Every identifier with all bits set: this drives each saturating
        // signal past its limit and each temperature past its upper limit.
        for (int unsigned i = 0; i < 12; i++)
        begin
            transmit_frame(known_frame_id(i), jfsd_pkg::DLC_FULL, '1);
        end
        // All-zero payloads give the lowest temperatures and zero counters.
        transmit_frame(jfsd_pkg::ID_ET1, jfsd_pkg::DLC_FULL, '0);
        transmit_frame(jfsd_pkg::ID_AMB, jfsd_pkg::DLC_FULL, '0);
        transmit_frame(jfsd_pkg::ID_VDHR, jfsd_pkg::DLC_FULL, '0);
        // Speed exactly on the clamp and one above it.
        transmit_frame(jfsd_pkg::ID_CCVS, jfsd_pkg::DLC_FULL, 64'h0000_0000_00FA_FF04);
        transmit_frame(jfsd_pkg::ID_CCVS, jfsd_pkg::DLC_FULL, 64'h0000_0000_20FB_0008);
        // Short and long frames on the identifiers that demand eight bytes
        // yield nothing; the others decode all eight bytes regardless.
        transmit_frame(jfsd_pkg::ID_CCVS, 4'd7, '1);
        transmit_frame(jfsd_pkg::ID_EEC1, 4'd0, '1);
        transmit_frame(jfsd_pkg::ID_EEC2, 4'd15, '1);
        transmit_frame(jfsd_pkg::ID_ET1, 4'd15, 64'h0000_0000_0000_2829);
        transmit_frame(jfsd_pkg::ID_DM1, 4'd0, 64'h0000_FF00_0000_0000);
        // Identifiers that match nothing, including a single-bit near miss.
        transmit_frame(29'h0000_0000, jfsd_pkg::DLC_FULL, '1);
        transmit_frame(29'h1FFF_FFFF, jfsd_pkg::DLC_FULL, '1);
        transmit_frame(jfsd_pkg::ID_CCVS ^ 29'h1, jfsd_pkg::DLC_FULL, '1);
        // Back-to-back frames of the three-signal kind wait in the queue.
        sender_gap_max = 0;
        transmit_frame(jfsd_pkg::ID_CCVS, jfsd_pkg::DLC_FULL, random_payload());
        transmit_frame(jfsd_pkg::ID_CCVS, jfsd_pkg::DLC_FULL, random_payload());
    endtask

    // Mostly well-formed frames with random contents, plus near-miss and
    // wholly random identifiers and odd DLCs. The idle gap switches
    // between none, short and long so that queue-full periods and gaps
    // inside every back-end phase both occur.
    task automatic test_random_frames();
        int unsigned choice;
        logic [28:0] id;
        logic [3:0]  dlc;
        for (int unsigned n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n % 16 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       sender_gap_max = 0;
                    1:       sender_gap_max = 3;
                    default: sender_gap_max = 18;
                endcase
            end
            choice = $urandom_range(0, 99);
            if (choice < 75)
            begin
                id = known_frame_id($urandom_range(0, 11));
            end
            else if (choice < 90)
            begin
                id = known_frame_id($urandom_range(0, 11)) ^ (29'h1 << $urandom_range(0, 28));
            end
            else
            begin
                id = 29'($urandom());
            end
            dlc = ($urandom_range(0, 99) < 85) ? jfsd_pkg::DLC_FULL
                                                : 4'($urandom_range(0, 15));
            transmit_frame(id, dlc, random_payload());
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------

    initial
    begin
        // Reset is held low at the start and then released for good.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_random_frames();

        // No further transactions: lower start once the last one is in.
        start <= 1'b0;

        // Wait for every owed signal, then a few cycles more so that any
        // stray strobe after the last expected one is caught.
        while (pending_signals.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
